// ===== src/oust_pkg.sv =====
// Package for the ordered unique set table: sizes, command and status codes,
// controller states and the control structs shared by the controller and datapath.
// No dependencies.
`default_nettype none

package oust_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CMP_W    = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_QUERY,
    CMD_READ
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED,
    ST_DUP,
    ST_FULL,
    ST_REMOVED,
    ST_ABSENT,
    ST_MEMBER,
    ST_NOTMEMBER,
    ST_RANGE
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_ctl_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/oust_ctrl.sv =====
// Controller for the ordered unique set table: accepts an item, then runs the
// update cycle once the result register is free. Depends on oust_pkg.
`default_nettype none

module oust_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire oust_pkg::dp_sts_t sts_i,
  output oust_pkg::dp_ctl_t      ctl_o
);
  import oust_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctl_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      S_EXEC: begin
        ctl_o.exec = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/oust_dp.sv =====
// Datapath for the ordered unique set table: entry cells with parallel compare,
// append and compaction shift, index read and the result register. Depends on oust_pkg.
`default_nettype none

module oust_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire oust_pkg::dp_ctl_t                      ctl_i,
  output oust_pkg::dp_sts_t                           sts_o,
  input  wire logic        [oust_pkg::CMD_W-1:0]      op_i,
  input  wire logic signed [oust_pkg::VALUE_W-1:0]    value_i,
  input  wire logic        [oust_pkg::INDEX_W-1:0]    index_i,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic             [oust_pkg::STATUS_W-1:0]   status_o,
  output logic signed      [oust_pkg::VALUE_W-1:0]    read_value_o,
  output logic             [oust_pkg::COUNT_W-1:0]    count_o
);
  import oust_pkg::*;

  logic [VALUE_W-1:0] entry_q [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;

  cmd_e               op_q;
  logic [VALUE_W-1:0] val_q;
  logic [INDEX_W-1:0] idx_q;
  logic               hit_any_q;
  logic [ADDR_W-1:0]  hit_pos_q;

  logic [CAPACITY-1:0] hit_vec;
  logic                hit_any;
  logic [ADDR_W-1:0]   hit_pos;

  logic               full;
  logic               rd_ok;
  logic               add_go;
  logic               rem_go;
  status_e            status_d;
  logic [VALUE_W-1:0] read_d;

  logic               out_valid_q;
  status_e            status_q;
  logic [VALUE_W-1:0] read_q;
  logic [COUNT_W-1:0] count_out_q;

  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = (CNT_W'(i) < count_q) && (entry_q[i] == value_i);
      if (hit_vec[i]) begin
        hit_pos = hit_pos | ADDR_W'(i);
      end
    end
    hit_any = |hit_vec;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q      <= cmd_e'(op_i);
      val_q     <= value_i;
      idx_q     <= index_i;
      hit_any_q <= hit_any;
      hit_pos_q <= hit_pos;
    end
  end

  always_comb begin
    full     = (count_q == CNT_W'(CAPACITY));
    rd_ok    = (CMP_W'(idx_q) < CMP_W'(count_q));
    add_go   = ctl_i.exec && (op_q == CMD_ADD) && !hit_any_q && !full;
    rem_go   = ctl_i.exec && (op_q == CMD_REMOVE) && hit_any_q;
    read_d   = '0;
    status_d = ST_RANGE;
    case (op_q)
      CMD_ADD: begin
        if (hit_any_q) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_ADDED;
        end
      end
      CMD_REMOVE: begin
        status_d = hit_any_q ? ST_REMOVED : ST_ABSENT;
      end
      CMD_QUERY: begin
        status_d = hit_any_q ? ST_MEMBER : ST_NOTMEMBER;
      end
      CMD_READ: begin
        if (rd_ok) begin
          status_d = ST_MEMBER;
          read_d   = entry_q[ADDR_W'(idx_q)];
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
    if (add_go) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_go) begin
      count_d = count_q - CNT_W'(1);
    end else begin
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] shift_in;
    if (g < CAPACITY - 1) begin : g_mid
      assign shift_in = entry_q[g+1];
    end else begin : g_last
      assign shift_in = entry_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (rem_go && (ADDR_W'(g) >= hit_pos_q)) begin
        entry_q[g] <= shift_in;
      end else if (add_go && (CNT_W'(g) == count_q)) begin
        entry_q[g] <= val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (ctl_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      status_q    <= status_d;
      read_q      <= read_d;
      count_out_q <= COUNT_W'(count_d);
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign read_value_o   = read_q;
  assign count_o        = count_out_q;

endmodule

`default_nettype wire

// ===== src/ordered_unique_set_table.sv =====
// Ordered unique set table: holds up to CAPACITY distinct 32-bit values in
// insertion order and answers add, remove, membership query and read by index,
// one result item per input item. In the cycle an item is accepted every entry
// cell compares the value in parallel and the hit is registered; in the execute
// state, once the result register is free, the table appends the value or shifts
// later entries down one place, and the result register loads. The next item
// is accepted once the last is through; a result not yet taken stalls only the
// update of the item after it. Depends on oust_pkg, oust_ctrl and oust_dp.
`default_nettype none

module ordered_unique_set_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [oust_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic signed [oust_pkg::VALUE_W-1:0] value_i,
  input  wire logic        [oust_pkg::INDEX_W-1:0] index_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [oust_pkg::STATUS_W-1:0] status_o,
  output logic signed      [oust_pkg::VALUE_W-1:0] read_value_o,
  output logic             [oust_pkg::COUNT_W-1:0] count_o
);
  import oust_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  oust_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  oust_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .op_i         (cmd_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

endmodule

`default_nettype wire
